[rtl/sdss_pkg.sv]
// ----------------------------------------------------------------------------
// Signed decimal scan package
// Shared widths, segment codes and the stage record of the conversion chain.
// ----------------------------------------------------------------------------
package sdss_pkg;

  localparam int unsigned ValueWidth = 15;
  localparam int unsigned MagWidth   = 14;
  localparam int unsigned DigitCount = 4;
  localparam int unsigned BcdWidth   = 4 * DigitCount;
  localparam int unsigned SegWidth   = 7;
  localparam int unsigned PosWidth   = 2;
  localparam int unsigned NumCells   = MagWidth;

  localparam logic signed [ValueWidth-1:0] MaxShown = 15'sd9999;
  localparam logic signed [ValueWidth-1:0] MinShown = -15'sd999;

  localparam logic [SegWidth-1:0] SegMinus = 7'h40;
  localparam logic [PosWidth-1:0] LastPos  = 2'd3;

  // One stage of the shift-and-add-three conversion.
  typedef struct packed {
    logic                valid;
    logic                neg;
    logic [MagWidth-1:0] bin;
    logic [BcdWidth-1:0] bcd;
  } dabble_t;

  function automatic logic [SegWidth-1:0] seg_of_digit(input logic [3:0] digit);
    logic [SegWidth-1:0] seg;
    case (digit)
      4'd0:    seg = 7'h3f;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5b;
      4'd3:    seg = 7'h4f;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6d;
      4'd6:    seg = 7'h7d;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7f;
      4'd9:    seg = 7'h6f;
      default: seg = '0;
    endcase
    return seg;
  endfunction

endpackage

[rtl/sdss_cell.sv]
// ----------------------------------------------------------------------------
// Conversion cell
// Corrects each BCD digit by three where it is five or more, then shifts one
// magnitude bit into the BCD word and hands the result to the next cell.
// ----------------------------------------------------------------------------
module sdss_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  sdss_pkg::dabble_t cell_i,
  output sdss_pkg::dabble_t cell_o
);
  import sdss_pkg::*;

  logic                valid_q;
  logic                neg_q;
  logic [MagWidth-1:0] bin_q, bin_d;
  logic [BcdWidth-1:0] bcd_q, bcd_d;
  logic [BcdWidth-1:0] bcd_adj;

  always_comb begin
    for (int i = 0; i < DigitCount; i++) begin
      if (cell_i.bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = cell_i.bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = cell_i.bcd[4*i +: 4];
      end
    end
    bcd_d = {bcd_adj[BcdWidth-2:0], cell_i.bin[MagWidth-1]};
    bin_d = {cell_i.bin[MagWidth-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      neg_q <= cell_i.neg;
      bin_q <= bin_d;
      bcd_q <= bcd_d;
    end
  end

  assign cell_o = '{valid: valid_q, neg: neg_q, bin: bin_q, bcd: bcd_q};

endmodule

[rtl/sdss_scan.sv]
// ----------------------------------------------------------------------------
// Digit scanner
// Holds the four segment patterns of one value and sends them out one digit
// per transaction, leftmost first.
// ----------------------------------------------------------------------------
module sdss_scan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_neg_i,
  input  logic [sdss_pkg::BcdWidth-1:0] in_bcd_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sdss_pkg::PosWidth-1:0] out_pos_o,
  output logic [sdss_pkg::DigitCount-1:0] out_enable_n_o,
  output logic [sdss_pkg::SegWidth-1:0] out_seg_o,
  output logic                          out_last_o
);
  import sdss_pkg::*;

  logic                busy_q;
  logic [PosWidth-1:0] cnt_q;
  logic [SegWidth-1:0] pat_q [DigitCount];
  logic                emit;
  logic                load;
  logic                done;

  assign emit       = busy_q && out_ready_i;
  assign done       = emit && (cnt_q == LastPos);
  assign in_ready_o = !busy_q || done;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (done) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (emit) begin
      cnt_q <= cnt_q + PosWidth'(1);
    end
  end

  // The patterns move toward slot 0, which always drives the segments.
  always_ff @(posedge clk_i) begin
    if (load) begin
      pat_q[0] <= in_neg_i ? SegMinus : seg_of_digit(in_bcd_i[15:12]);
      pat_q[1] <= seg_of_digit(in_bcd_i[11:8]);
      pat_q[2] <= seg_of_digit(in_bcd_i[7:4]);
      pat_q[3] <= seg_of_digit(in_bcd_i[3:0]);
    end else if (emit) begin
      for (int i = 0; i < DigitCount - 1; i++) begin
        pat_q[i] <= pat_q[i+1];
      end
    end
  end

  assign out_valid_o    = busy_q;
  assign out_pos_o      = cnt_q;
  assign out_enable_n_o = ~(DigitCount'(1) << cnt_q);
  assign out_seg_o      = pat_q[0];
  assign out_last_o     = (cnt_q == LastPos);

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && busy_q) |-> (out_ready_i && (cnt_q == LastPos)))
    else $error("new value loaded over an unfinished run");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && !in_valid_i) |=> !busy_q)
    else $error("scanner still busy after the last digit");

  a_count_rests_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (cnt_q == '0))
    else $error("digit count moved while idle");

  a_one_digit_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> $onehot(~out_enable_n_o))
    else $error("more than one digit enabled");

endmodule

[rtl/signed_decimal_seven_segment_scan_unit.sv]
// ----------------------------------------------------------------------------
// Signed decimal seven-segment scan unit
// Converts a signed value to four multiplexed seven-segment digit drives.
// ----------------------------------------------------------------------------
// Each value in -999..9999 yields four output transactions, leftmost digit
// first, one per cycle while the sink is ready; the single digit scanner at
// the output sets the pace of a steady stream. Values outside that range are
// accepted and dropped. The binary to BCD conversion is a chain of fourteen
// shift-and-add-three cells, one per magnitude bit; a value passes through
// the fourteen cell registers to the scanner, whose pattern registers then
// drive its first digit. The whole chain stalls only while its last cell
// holds a value the scanner cannot yet take.
module signed_decimal_seven_segment_scan_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [14:0] value
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [1:0] digit_position, [5:2] digit_enable_n,
                                        // [12:6] segments, [15:13] zero
  output logic        m_axis_tlast_o
);
  import sdss_pkg::*;

  logic signed [ValueWidth-1:0] value;
  logic [ValueWidth-1:0]        neg_value;
  logic                         in_range;
  logic                         advance;
  logic                         scan_ready;
  dabble_t                      stage [NumCells+1];

  logic [PosWidth-1:0]   out_pos;
  logic [DigitCount-1:0] out_enable_n;
  logic [SegWidth-1:0]   out_seg;

  assign value     = s_axis_tdata_i[ValueWidth-1:0];
  assign neg_value = ValueWidth'(-value);
  assign in_range  = (value <= MaxShown) && (value >= MinShown);

  assign stage[0] = '{
    valid: s_axis_tvalid_i && in_range,
    neg:   value[ValueWidth-1],
    bin:   value[ValueWidth-1] ? neg_value[MagWidth-1:0] : value[MagWidth-1:0],
    bcd:   '0
  };

  assign advance         = !stage[NumCells].valid || scan_ready;
  assign s_axis_tready_o = advance;

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    sdss_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .cell_i    (stage[g]),
      .cell_o    (stage[g+1])
    );
  end

  sdss_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (stage[NumCells].valid),
    .in_neg_i       (stage[NumCells].neg),
    .in_bcd_i       (stage[NumCells].bcd),
    .in_ready_o     (scan_ready),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_pos_o      (out_pos),
    .out_enable_n_o (out_enable_n),
    .out_seg_o      (out_seg),
    .out_last_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {3'b000, out_seg, out_enable_n, out_pos};

  a_stall_holds_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(stage[NumCells].bcd))
    else $error("conversion chain moved during a stall");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |-> (stage[NumCells].valid && m_axis_tvalid_o))
    else $error("chain stalled without a waiting value");

  a_drop_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && advance && !in_range) |=> !stage[1].valid)
    else $error("out of range value entered the chain");

endmodule
